FILE: src/adu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adu_pkg - shared types and constants for the APIC topology decoder
// Beat payloads, divider request/response groups, action and level-type
// codes, and the shift helpers used by the decode logic.
// ----------------------------------------------------------------------------
package adu_pkg;

	// action codes
	localparam logic [1:0] ACT_BEGIN  = 2'd0;
	localparam logic [1:0] ACT_RECORD = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	// sub-leaf level types (ECX[15:8])
	localparam logic [7:0] LT_SMT  = 8'h01;
	localparam logic [7:0] LT_CORE = 8'h02;

	// extended path needs basic leaf 0x0B
	localparam logic [31:0] EXT_MIN_LEAF = 32'h0000_000B;

	// sub-leaf record limit
	localparam int          LVL_W      = 4;
	localparam logic [LVL_W-1:0] MAX_LEVELS = 4'd8;

	// divider geometry: 8-bit dividend, 7-bit divisor
	localparam int DIV_STEPS = 8;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] apic_in;
		logic [31:0] max_leaf;
		logic [7:0]  logical_count;
		logic [5:0]  cores_field;
		logic [31:0] sub_eax;
		logic [31:0] sub_ebx;
		logic [31:0] sub_ecx;
		logic [31:0] sub_edx;
	} cmd_item_t;

	typedef struct packed {
		logic        decoded;
		logic        used_extended;
		logic [31:0] apic_out;
		logic [15:0] pkg_number;
		logic [15:0] core_number;
		logic [7:0]  thread_number;
	} res_item_t;

	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [6:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quotient;
	} div_rsp_t;

	// bits needed to cover n distinct values, 0 for n <= 1
	function automatic logic [3:0] bits_to_cover(input logic [7:0] n);
		logic [7:0] v;
		logic [3:0] s;
		v = n - 8'd1;
		s = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) s = 4'(i + 1);
		end
		if (n <= 8'd1) s = 4'd0;
		return s;
	endfunction

	// mask of the low s bits, s up to 31
	function automatic logic [31:0] low_mask(input logic [4:0] s);
		return (32'h1 << s) - 32'h1;
	endfunction

endpackage

FILE: src/adu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adu_if - valid/ready channels for the APIC topology decoder
// Command channel carries begin, record and finish beats; result channel
// carries one decode per finish.
// ----------------------------------------------------------------------------
interface adu_cmd_if;
	logic               valid;
	logic               ready;
	adu_pkg::cmd_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface adu_res_if;
	logic               valid;
	logic               ready;
	adu_pkg::res_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/adu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adu_div - restoring divider, one quotient bit per cycle
// Divides the 8-bit logical count by the 7-bit core count with a single
// shared compare/subtract stage; done pulses after eight steps.
// ----------------------------------------------------------------------------
module adu_div (
	input  logic              clk,
	input  logic              arst_n,
	input  adu_pkg::div_req_t req,
	output adu_pkg::div_rsp_t rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [adu_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [6:0]                   rem_q;
	logic [7:0]                   quo_q;
	logic [6:0]                   dvs_q;

	// trial subtract of the shifted remainder
	logic [7:0] trial;
	logic       fits;
	logic [7:0] diff;

	assign trial = {rem_q, quo_q[7]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == adu_pkg::DIV_CNT_W'(adu_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[6:0] : trial[6:0];
			quo_q <= {quo_q[6:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: src/apic_topology_decode_unit.sv
`timescale 1ns / 1ps
// Begin, record and action-3 beats produce no result and leave the decoder idle.
// A finish beat issues the divider as it is accepted, then takes 8 divider
// steps and one result load; no beat is accepted while the divider runs, and
// the next beat is accepted no earlier than the decode is taken.
// Async reset clears all decode state to zero; no result is pending after reset.
// ----------------------------------------------------------------------------
// apic_topology_decode_unit - APIC ID to package/core/thread decoder
// Collects extended topology sub-leaf records after a begin beat and, on a
// finish beat, decodes through the extended path or the legacy shifts, or flags a failed decode.
// ----------------------------------------------------------------------------
module apic_topology_decode_unit (
	input  logic          clk,
	input  logic          arst_n,
	adu_cmd_if.sink       cmd,
	adu_res_if.source     res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;

	logic [1:0] state_q;

	// decode state
	logic [31:0]              start_apic_q;
	logic                     ext_allowed_q;
	logic [7:0]               logical_q;
	logic [5:0]               cores_q;
	logic [4:0]               thread_shift_q;
	logic [4:0]               pkg_shift_q;
	logic [31:0]              last_xapic_q;
	logic                     saw_level_q;
	logic                     enum_ended_q;
	logic [adu_pkg::LVL_W-1:0] level_count_q;

	logic               res_valid_q;
	adu_pkg::res_item_t res_q;

	adu_pkg::div_req_t div_req;
	adu_pkg::div_rsp_t div_rsp;

	logic cmd_acc;
	assign cmd.ready = (state_q == ST_IDLE) && (!res_valid_q || res.ready);
	assign cmd_acc   = cmd.valid && cmd.ready;

	// divider issue on finish
	assign div_req.start    = cmd_acc && (cmd.payload.action == adu_pkg::ACT_FINISH);
	assign div_req.dividend = logical_q;
	assign div_req.divisor  = {1'b0, cores_q} + 7'd1;

	adu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// record decode
	logic [7:0] ltype;
	logic       rec_take;
	logic       rec_end;
	assign ltype    = cmd.payload.sub_ecx[15:8];
	assign rec_take = !enum_ended_q && (level_count_q < adu_pkg::MAX_LEVELS);
	assign rec_end  = (cmd.payload.sub_eax == 32'h0) && (cmd.payload.sub_ebx == 32'h0);

	// sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			start_apic_q   <= '0;
			ext_allowed_q  <= 1'b0;
			logical_q      <= '0;
			cores_q        <= '0;
			thread_shift_q <= '0;
			pkg_shift_q    <= '0;
			last_xapic_q   <= '0;
			saw_level_q    <= 1'b0;
			enum_ended_q   <= 1'b0;
			level_count_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						unique case (cmd.payload.action)
							adu_pkg::ACT_BEGIN: begin
								start_apic_q   <= cmd.payload.apic_in;
								ext_allowed_q  <= cmd.payload.max_leaf >= adu_pkg::EXT_MIN_LEAF;
								logical_q      <= cmd.payload.logical_count;
								cores_q        <= cmd.payload.cores_field;
								thread_shift_q <= '0;
								pkg_shift_q    <= '0;
								last_xapic_q   <= cmd.payload.apic_in;
								saw_level_q    <= 1'b0;
								enum_ended_q   <= 1'b0;
								level_count_q  <= '0;
							end
							adu_pkg::ACT_RECORD: begin
								if (rec_take) begin
									if (rec_end) begin
										enum_ended_q <= 1'b1;
									end else begin
										if (ltype == adu_pkg::LT_SMT)
											thread_shift_q <= cmd.payload.sub_eax[4:0];
										else if (ltype == adu_pkg::LT_CORE)
											pkg_shift_q <= cmd.payload.sub_eax[4:0];
										last_xapic_q  <= cmd.payload.sub_edx;
										saw_level_q   <= 1'b1;
										level_count_q <= level_count_q + 1'b1;
									end
								end
							end
							adu_pkg::ACT_FINISH: begin
								state_q <= ST_DIV;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_rsp.done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// final decode from divider result
	logic [7:0]  per_core;
	logic [3:0]  pshift;
	logic [3:0]  sshift;
	logic        ext_ok;
	logic        leg_ok;
	logic        ok;
	logic [31:0] src;
	logic [4:0]  ts;
	logic [4:0]  cs;
	logic [31:0] thr;
	logic [31:0] core;
	logic [31:0] pkg;

	always_comb begin
		per_core = (div_rsp.quotient == 8'd0) ? 8'd1 : div_rsp.quotient;
		pshift   = adu_pkg::bits_to_cover(logical_q);
		sshift   = adu_pkg::bits_to_cover(per_core);
		ext_ok   = ext_allowed_q && saw_level_q && (pkg_shift_q >= thread_shift_q);
		leg_ok   = (logical_q != 8'd0) && (pshift >= sshift);
		ok       = ext_ok || leg_ok;
		src      = ext_ok ? last_xapic_q : start_apic_q;
		ts       = ext_ok ? thread_shift_q : {1'b0, sshift};
		cs       = ext_ok ? pkg_shift_q : {1'b0, pshift};
		thr      = src & adu_pkg::low_mask(ts);
		core     = (src >> ts) & adu_pkg::low_mask(cs - ts);
		pkg      = src >> cs;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_DIV) && div_rsp.done) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_rsp.done) begin
			res_q.decoded       <= ok;
			res_q.used_extended <= ext_ok;
			res_q.apic_out      <= src;
			res_q.pkg_number    <= ok ? pkg[15:0] : 16'h0;
			res_q.core_number   <= ok ? core[15:0] : 16'h0;
			res_q.thread_number <= ok ? thr[7:0] : 8'h0;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

endmodule

FILE: src/adu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adu_checker - port-level checks for the APIC topology decoder
// Watches the command and result channels for latency, stall and decode
// consistency; bound to the top level below.
// ----------------------------------------------------------------------------
module adu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input adu_pkg::cmd_item_t cmd_payload,
	input logic               res_valid,
	input logic               res_ready,
	input adu_pkg::res_item_t res_payload
);

	logic fin_acc;
	assign fin_acc = cmd_valid && cmd_ready && (cmd_payload.action == adu_pkg::ACT_FINISH);

	// a rising result valid traces back to a finish beat, through the divider run and the result load
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(fin_acc, 10))
		else $error("result without finish beat ten cycles earlier");

	// busy right after a finish beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_acc |=> !cmd_ready)
		else $error("command accepted during decode");

	// failed decode carries zero ids and no extended flag
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_payload.decoded) |->
			(res_payload.pkg_number == 16'h0) && (res_payload.core_number == 16'h0) &&
			(res_payload.thread_number == 8'h0) && !res_payload.used_extended)
		else $error("failed decode with nonzero fields");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_payload)))
		else $error("stalled result changed");

endmodule

bind apic_topology_decode_unit adu_checker u_adu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_payload (cmd.payload),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_payload (res.payload)
);

FILE: sim/apic_topology_decode_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apic_topology_decode_unit_tb - self-checking bench for the topology decoder
// A queue of begin, sub-leaf record and finish beats drives the command
// channel. Every accepted beat also updates a local model of the decode
// state, and each finish queues the decode that the model expects. A monitor
// compares every result beat with the oldest queued decode. Random gaps on
// both channels shift between three phases.
// ----------------------------------------------------------------------------
module apic_topology_decode_unit_tb;

	// action 3 is not defined and must be ignored
	localparam logic [1:0] ACT_NONE = 2'd3;
	// a level type that is neither SMT nor core
	localparam logic [7:0] LT_OTHER = 8'h05;

	localparam int RANDOM_ITEMS = 450;
	localparam int DRAIN_CYCLES = 20;

	// decode state as the model sees it
	typedef struct {
		logic [31:0] start_apic;
		bit          ext_ok;
		logic [7:0]  logical;
		logic [5:0]  cores;
		logic [4:0]  thr_shift;
		logic [4:0]  pkg_shift;
		logic [31:0] x2apic;
		bit          have_level;
		bit          enum_done;
		logic [3:0]  levels;
	} topo_state_t;

	logic clk;
	logic arst_n;

	adu_cmd_if cmd_ch ();
	adu_res_if res_ch ();

	apic_topology_decode_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	topo_state_t          topo;
	adu_pkg::cmd_item_t   stim_q[$];
	adu_pkg::res_item_t   decode_q[$];
	int                   stim_total;
	int                   beats_done;
	int                   errors;
	bit                   cmd_taken;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

	// bits needed to tell n values apart
	function automatic int cover_bits(input int n);
		int s;
		s = 0;
		if (n > 1) begin
			for (int v = n - 1; v != 0; v = v >> 1) s++;
		end
		return s;
	endfunction

	function automatic logic [31:0] mask_lo(input int s);
		logic [63:0] m;
		m = (64'd1 << s) - 64'd1;
		return m[31:0];
	endfunction

	// model: one accepted command beat
	task automatic apply_beat(input adu_pkg::cmd_item_t b);
		adu_pkg::res_item_t r;
		int        cores;
		int        per_core;
		int        pshift;
		int        sshift;
		int        smt;
		int        cor;
		logic [7:0] lt;
		case (b.action)
			adu_pkg::ACT_BEGIN: begin
				topo.start_apic = b.apic_in;
				topo.ext_ok     = (b.max_leaf >= adu_pkg::EXT_MIN_LEAF);
				topo.logical    = b.logical_count;
				topo.cores      = b.cores_field;
				topo.thr_shift  = '0;
				topo.pkg_shift  = '0;
				topo.x2apic     = b.apic_in;
				topo.have_level = 1'b0;
				topo.enum_done  = 1'b0;
				topo.levels     = '0;
			end
			adu_pkg::ACT_RECORD: begin
				if (!topo.enum_done && topo.levels < adu_pkg::MAX_LEVELS) begin
					if (b.sub_eax == 32'd0 && b.sub_ebx == 32'd0) begin
						topo.enum_done = 1'b1;
					end else begin
						lt = b.sub_ecx[15:8];
						if (lt == adu_pkg::LT_SMT) topo.thr_shift = b.sub_eax[4:0];
						else if (lt == adu_pkg::LT_CORE) topo.pkg_shift = b.sub_eax[4:0];
						topo.x2apic     = b.sub_edx;
						topo.have_level = 1'b1;
						topo.levels     = topo.levels + 4'd1;
					end
				end
			end
			adu_pkg::ACT_FINISH: begin
				r = '0;
				r.apic_out = topo.start_apic;
				smt = int'(topo.thr_shift);
				cor = int'(topo.pkg_shift);
				if (topo.ext_ok && topo.have_level && cor >= smt) begin
					r.decoded       = 1'b1;
					r.used_extended = 1'b1;
					r.apic_out      = topo.x2apic;
					r.thread_number = 8'(topo.x2apic & mask_lo(smt));
					r.core_number   = 16'((topo.x2apic >> smt) & mask_lo(cor - smt));
					r.pkg_number    = 16'(topo.x2apic >> cor);
				end else if (topo.logical != 8'd0) begin
					// legacy: shifts from the logical count and from logical / cores
					cores    = int'(topo.cores) + 1;
					per_core = int'(topo.logical) / cores;
					if (per_core == 0) per_core = 1;
					pshift = cover_bits(int'(topo.logical));
					sshift = cover_bits(per_core);
					if (pshift >= sshift) begin
						r.decoded       = 1'b1;
						r.thread_number = 8'(topo.start_apic & mask_lo(sshift));
						r.core_number   = 16'((topo.start_apic >> sshift)
							& mask_lo(pshift - sshift));
						r.pkg_number    = 16'(topo.start_apic >> pshift);
					end
				end
				decode_q.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// beat builders; fields the action does not use stay random
	function automatic adu_pkg::cmd_item_t noise_item();
		adu_pkg::cmd_item_t it;
		it.action        = 2'($urandom_range(0, 3));
		it.apic_in       = $urandom;
		it.max_leaf      = $urandom;
		it.logical_count = 8'($urandom);
		it.cores_field   = 6'($urandom);
		it.sub_eax       = $urandom;
		it.sub_ebx       = $urandom;
		it.sub_ecx       = $urandom;
		it.sub_edx       = $urandom;
		return it;
	endfunction

	function automatic adu_pkg::cmd_item_t begin_item(input logic [31:0] apic,
		input logic [31:0] leaf, input logic [7:0] logical, input logic [5:0] cores);
		adu_pkg::cmd_item_t it;
		it               = noise_item();
		it.action        = adu_pkg::ACT_BEGIN;
		it.apic_in       = apic;
		it.max_leaf      = leaf;
		it.logical_count = logical;
		it.cores_field   = cores;
		return it;
	endfunction

	function automatic adu_pkg::cmd_item_t record_item(input logic [31:0] eax,
		input logic [31:0] ebx, input logic [31:0] ecx, input logic [31:0] edx);
		adu_pkg::cmd_item_t it;
		it         = noise_item();
		it.action  = adu_pkg::ACT_RECORD;
		it.sub_eax = eax;
		it.sub_ebx = ebx;
		it.sub_ecx = ecx;
		it.sub_edx = edx;
		return it;
	endfunction

	function automatic adu_pkg::cmd_item_t finish_item();
		adu_pkg::cmd_item_t it;
		it        = noise_item();
		it.action = adu_pkg::ACT_FINISH;
		return it;
	endfunction

	function automatic logic [31:0] lvl_ecx(input logic [7:0] lt);
		return {16'($urandom), lt, 8'($urandom)};
	endfunction

	function automatic logic [31:0] shift_eax(input logic [4:0] sh);
		logic [31:0] w;
		w = $urandom;
		return {w[31:5], sh};
	endfunction

	// idle rates per phase: receiver-heavy stall, sender-heavy, none
	function automatic int send_idle_pct();
		if (beats_done < stim_total / 3) return 21;
		if (beats_done < 2 * stim_total / 3) return 69;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (beats_done < stim_total / 3) return 69;
		if (beats_done < 2 * stim_total / 3) return 21;
		return 0;
	endfunction

	// stimulus, reset and end of run
	initial begin
		int          n_directed;
		int          nrec;
		int          pick;
		logic [4:0]  smt_sh;
		logic [4:0]  core_sh;
		logic [7:0]  lt;
		logic [7:0]  lcount;
		logic [31:0] leaf;
		logic [31:0] ebx;

		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.payload = '0;
		res_ch.ready   = 1'b0;
		topo           = '{default: '0};
		beats_done     = 0;
		errors         = 0;
		cmd_taken      = 1'b0;
		stim_total     = 1;

		// finish straight out of reset, then an undefined action
		stim_q.push_back(finish_item());
		begin
			adu_pkg::cmd_item_t it;
			it        = noise_item();
			it.action = ACT_NONE;
			stim_q.push_back(it);
		end
		// all-ones extremes, end marker, record past the end, repeated finish
		stim_q.push_back(begin_item('1, '1, 8'hFF, 6'h3F));
		stim_q.push_back(record_item(32'hFFFF_FFE1, '1, 32'hFFFF_01FF, '1));
		stim_q.push_back(record_item('1, '1, 32'hFFFF_02FF, '1));
		stim_q.push_back(record_item('0, '0, '1, '0));
		stim_q.push_back(record_item(32'h0000_001F, 32'h1, 32'h0000_0100, 32'h55));
		stim_q.push_back(finish_item());
		stim_q.push_back(finish_item());
		// leaf too low for the extended path: records kept but unused
		stim_q.push_back(begin_item(32'h1234_5678, 32'h0000_000A, 8'd16, 6'd3));
		stim_q.push_back(record_item(32'h1, 32'h2, 32'h0000_0100, 32'h99));
		stim_q.push_back(record_item(32'h4, 32'h8, 32'h0000_0200, 32'h99));
		stim_q.push_back(finish_item());
		// core shift below SMT shift, zero logical count: both paths fail
		stim_q.push_back(begin_item($urandom, adu_pkg::EXT_MIN_LEAF, 8'd0, 6'd0));
		stim_q.push_back(record_item(32'h5, 32'h2, 32'h0000_0100, $urandom));
		stim_q.push_back(record_item(32'h2, 32'h4, 32'h0000_0200, $urandom));
		stim_q.push_back(finish_item());
		// other level types, one more record than the limit allows
		stim_q.push_back(begin_item('0, adu_pkg::EXT_MIN_LEAF, 8'd1, 6'd0));
		for (int i = 0; i < 9; i++) begin
			stim_q.push_back(record_item(shift_eax(5'(i)), 32'h1,
				lvl_ecx(LT_OTHER), 32'h100 + i));
		end
		stim_q.push_back(finish_item());
		// legacy with a single core
		stim_q.push_back(begin_item('1, '0, 8'hFF, 6'd0));
		stim_q.push_back(finish_item());
		n_directed = stim_q.size();

		// random part: mostly well-formed enumerations, some noise
		while (stim_q.size() < n_directed + RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 85) begin
				pick = $urandom_range(0, 9);
				leaf = (pick == 0) ? 32'($urandom_range(0, 10)) :
					(pick < 5) ? adu_pkg::EXT_MIN_LEAF : $urandom;
				pick = $urandom_range(0, 9);
				lcount = (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF :
					(pick == 2) ? 8'd1 : 8'($urandom);
				stim_q.push_back(begin_item($urandom, leaf, lcount, 6'($urandom)));
				smt_sh  = 5'($urandom_range(0, 4));
				core_sh = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
					smt_sh + 5'($urandom_range(0, 10));
				nrec = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) :
					$urandom_range(0, 3);
				for (int i = 0; i < nrec; i++) begin
					pick = $urandom_range(0, 9);
					if (i == 0) lt = adu_pkg::LT_SMT;
					else if (i == 1) lt = adu_pkg::LT_CORE;
					else lt = (pick < 3) ? adu_pkg::LT_SMT :
						(pick < 6) ? adu_pkg::LT_CORE : 8'($urandom);
					ebx = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
					stim_q.push_back(record_item(
						shift_eax((lt == adu_pkg::LT_CORE) ? core_sh : smt_sh),
						ebx, lvl_ecx(lt), $urandom));
				end
				if ($urandom_range(0, 9) < 6) begin
					stim_q.push_back(record_item('0, '0, $urandom, $urandom));
					if ($urandom_range(0, 9) < 3) begin
						stim_q.push_back(record_item(shift_eax(5'($urandom)), $urandom,
							lvl_ecx(adu_pkg::LT_SMT), $urandom));
					end
				end
				stim_q.push_back(finish_item());
				if ($urandom_range(0, 99) < 15) stim_q.push_back(finish_item());
			end else begin
				stim_q.push_back(noise_item());
			end
		end
		stim_total = stim_q.size();

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		wait (beats_done == stim_total);
		wait (decode_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// command driver: holds a beat until taken, then maybe idles
	always @(negedge clk) begin
		adu_pkg::cmd_item_t nxt_pay;
		logic               nxt_vld;
		nxt_vld = cmd_ch.valid;
		nxt_pay = cmd_ch.payload;
		if (arst_n === 1'b1) begin
			if (cmd_taken) nxt_vld = 1'b0;
			if (!nxt_vld && stim_q.size() != 0 &&
				$urandom_range(0, 99) >= send_idle_pct()) begin
				nxt_pay = stim_q.pop_front();
				nxt_vld = 1'b1;
			end
		end else begin
			nxt_vld = 1'b0;
		end
		cmd_ch.valid   <= nxt_vld;
		cmd_ch.payload <= nxt_pay;
	end

	// result backpressure
	always @(negedge clk) begin
		res_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct());
	end

	// monitor: check result beats, feed accepted command beats to the model
	always @(posedge clk) begin
		adu_pkg::res_item_t want;
		adu_pkg::res_item_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.payload;
			if (decode_q.size() == 0) begin
				$error("result beat with no decode pending");
				errors++;
			end else begin
				want = decode_q.pop_front();
				check_field("decoded", 32'(want.decoded), 32'(got.decoded));
				check_field("used_extended", 32'(want.used_extended),
					32'(got.used_extended));
				check_field("apic_out", want.apic_out, got.apic_out);
				check_field("pkg_number", 32'(want.pkg_number), 32'(got.pkg_number));
				check_field("core_number", 32'(want.core_number), 32'(got.core_number));
				check_field("thread_number", 32'(want.thread_number),
					32'(got.thread_number));
			end
		end
		cmd_taken = arst_n && cmd_ch.valid && cmd_ch.ready;
		if (cmd_taken) begin
			apply_beat(cmd_ch.payload);
			beats_done++;
		end
	end

endmodule
